@@ design/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// Photoperiod light sequencer package
// Shared types, codes, constants and the fade tables of the sequencer.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int FADE_MINUTES = 10;
  localparam int FADE_IDX_W   = $clog2(FADE_MINUTES + 1);

  localparam logic [7:0]  DUTY_MIN        = 8'd20;
  localparam logic [7:0]  DUTY_MAX        = 8'd255;
  localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;

  localparam logic [10:0] DAY_MINUTES_RESET      = 11'd1080;
  localparam logic [15:0] DOUBLE_PRESS_MS_RESET  = 16'd300;
  localparam logic [7:0]  DIM_HOLD_MINUTES_RESET = 8'd15;

  localparam logic [1:0] CFG_DAY_MINUTES      = 2'd0;
  localparam logic [1:0] CFG_DOUBLE_PRESS_MS  = 2'd1;
  localparam logic [1:0] CFG_DIM_HOLD_MINUTES = 2'd2;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_LOW  = 2'd2,
    MODE_MUTE = 2'd3
  } light_mode_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] gap_ms;
  } pls_in_t;

  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic        light_enable;
    logic [1:0]  light_mode;
    logic        daytime;
    logic [15:0] days_grown;
    logic [10:0] phase_minutes;
    logic [7:0]  dim_left;
  } pls_out_t;

  typedef struct packed {
    logic [10:0] day_minutes;
    logic [15:0] double_press_ms;
    logic [7:0]  dim_hold_minutes;
  } pls_cfg_t;

  typedef struct packed {
    light_mode_t mode;
    logic [7:0]  duty;
    logic        enable;
    logic        is_day;
    logic [10:0] minutes;
    logic [15:0] days;
    logic [7:0]  dim;
  } pls_state_t;

  typedef logic [7:0] fade_tab_t [0:FADE_MINUTES];

  // Duty for each elapsed fade minute, rising from the minimum or falling from full.
  function automatic fade_tab_t fade_table(input logic rising);
    fade_tab_t tab;
    int        pct;
    for (int k = 0; k <= FADE_MINUTES; k++) begin
      pct = k * 100 / FADE_MINUTES;
      if (rising) begin
        tab[k] = 8'(20 + 235 * pct / 100);
      end else begin
        tab[k] = 8'(255 - 235 * pct / 100);
      end
    end
    return tab;
  endfunction

  localparam fade_tab_t FADE_RISE = fade_table(1'b1);
  localparam fade_tab_t FADE_FALL = fade_table(1'b0);

endpackage

@@ design/pls_in_if.sv @@
// ----------------------------------------------------------------------------
// Photoperiod light sequencer input channel
// Valid/ready channel carrying one tick or button release word.
// ----------------------------------------------------------------------------
interface pls_in_if import pls_pkg::*; ();
  logic    valid;
  logic    ready;
  pls_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pls_out_if.sv @@
// ----------------------------------------------------------------------------
// Photoperiod light sequencer result channel
// Valid/ready channel carrying one light status word.
// ----------------------------------------------------------------------------
interface pls_out_if import pls_pkg::*; ();
  logic     valid;
  logic     ready;
  pls_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pls_step.sv @@
// ----------------------------------------------------------------------------
// Photoperiod light sequencer step logic
// Next light state for one tick or button release word.
// ----------------------------------------------------------------------------
module pls_step import pls_pkg::*; (
  input  pls_state_t state,
  input  pls_cfg_t   cfg,
  input  pls_in_t    item,
  output pls_state_t state_next
);

  logic [10:0]           day_len;
  logic [10:0]           night_len;
  logic [10:0]           phase_len;
  logic [10:0]           minute_inc;
  logic [11:0]           ramp_sum;
  logic [11:0]           ramp_diff;
  logic [FADE_IDX_W-1:0] ramp_step;

  always_comb begin
    day_len    = (cfg.day_minutes > MINUTES_PER_DAY) ? MINUTES_PER_DAY : cfg.day_minutes;
    night_len  = MINUTES_PER_DAY - day_len;
    phase_len  = state.is_day ? day_len : night_len;
    minute_inc = state.minutes + 11'd1;
    ramp_sum   = {1'b0, minute_inc} + 12'(FADE_MINUTES);
    ramp_diff  = ramp_sum - {1'b0, phase_len};
    ramp_step  = ramp_diff[FADE_IDX_W-1:0];

    state_next = state;
    if (item.operation == OP_TICK) begin
      if (state.mode == MODE_LOW) begin
        state_next.dim = state.dim - 8'd1;
        if (state_next.dim == 8'd0) begin
          state_next.mode   = MODE_HIGH;
          state_next.duty   = DUTY_MAX;
          state_next.enable = 1'b1;
        end
      end
      state_next.minutes = minute_inc;
      if (minute_inc > phase_len) begin
        state_next.minutes = 11'd0;
        if (state.is_day) begin
          state_next.enable = 1'b0;
          state_next.mode   = MODE_OFF;
          state_next.is_day = 1'b0;
        end else begin
          state_next.days   = state.days + 16'd1;
          state_next.mode   = MODE_HIGH;
          state_next.duty   = DUTY_MAX;
          state_next.enable = 1'b1;
          state_next.is_day = 1'b1;
        end
      end else if (ramp_sum >= {1'b0, phase_len}) begin
        if (state.is_day && state_next.mode == MODE_HIGH) begin
          state_next.duty   = FADE_FALL[ramp_step];
          state_next.enable = 1'b1;
        end else if (!state.is_day && state_next.mode == MODE_OFF) begin
          state_next.duty   = FADE_RISE[ramp_step];
          state_next.enable = 1'b1;
        end
      end
    end else begin
      if (item.gap_ms <= cfg.double_press_ms && state.mode == MODE_LOW) begin
        state_next.enable = 1'b0;
        state_next.mode   = MODE_MUTE;
      end else if (state.mode == MODE_HIGH) begin
        state_next.duty   = DUTY_MIN;
        state_next.enable = 1'b1;
        state_next.mode   = MODE_LOW;
        state_next.dim    = cfg.dim_hold_minutes;
      end else if (state.mode == MODE_LOW || state.mode == MODE_MUTE) begin
        state_next.mode   = MODE_HIGH;
        state_next.duty   = DUTY_MAX;
        state_next.enable = 1'b1;
      end
    end
  end

endmodule

@@ design/photoperiod_light_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Photoperiod light sequencer
// Runs a grow light through day and night with fades, dimming and muting.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Word
//  items     in         valid/ready        operation, gap_ms
//  results   out        valid/ready        light status after the word
//  cfg       in         cfg_write strobe   cfg_index, cfg_data
//
// An accepted word gives its result the next cycle; one per cycle unless stalled.
// The light state and the result register are written in the same cycle.
// A waiting result stalls input only if it is not taken in that cycle.
// Synchronous reset restores the light state and the register defaults.
// ----------------------------------------------------------------------------
module photoperiod_light_sequencer_unit import pls_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pls_in_if.sink        items,
  pls_out_if.source     results,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  pls_cfg_t   cfg;
  pls_state_t state;
  pls_state_t state_next;
  pls_out_t   result;
  logic       result_valid;
  logic       accept;

  assign items.ready   = !result_valid || results.ready;
  assign accept        = items.valid && items.ready;
  assign results.valid = result_valid;
  assign results.data  = result;

  pls_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (items.data),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.day_minutes      <= DAY_MINUTES_RESET;
      cfg.double_press_ms  <= DOUBLE_PRESS_MS_RESET;
      cfg.dim_hold_minutes <= DIM_HOLD_MINUTES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DAY_MINUTES:      cfg.day_minutes      <= cfg_data[10:0];
        CFG_DOUBLE_PRESS_MS:  cfg.double_press_ms  <= cfg_data;
        CFG_DIM_HOLD_MINUTES: cfg.dim_hold_minutes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode    <= MODE_OFF;
      state.duty    <= DUTY_MAX;
      state.enable  <= 1'b0;
      state.is_day  <= 1'b0;
      state.minutes <= 11'd0;
      state.days    <= 16'd0;
      state.dim     <= 8'd0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (results.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.pwm_duty      <= state_next.duty;
      result.light_enable  <= state_next.enable;
      result.light_mode    <= state_next.mode;
      result.daytime       <= state_next.is_day;
      result.days_grown    <= state_next.days;
      result.phase_minutes <= state_next.minutes;
      result.dim_left      <= state_next.dim;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted word gave no result");

  a_muted_dark: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_MUTE |-> !state.enable)
    else $error("muted light is switched on");

  a_lit_modes_on: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_HIGH || state.mode == MODE_LOW) |-> state.enable)
    else $error("light in high or low mode is switched off");

  a_dimmed_duty: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_LOW |-> state.duty == DUTY_MIN)
    else $error("dimmed light is not at minimum duty");

  a_day_count: assert property (@(posedge clk) disable iff (rst)
    $rose(state.is_day) |-> state.days == 16'($past(state.days) + 16'd1))
    else $error("sunrise did not count a day");

endmodule
